>>> rtl/core/ldsp_pkg.sv
// ----------------------------------------------------------------------------
// ldsp_pkg
// Shared types and constants for the lax DER signature parser.
// ----------------------------------------------------------------------------
package ldsp_pkg;

	// DER codes
	localparam logic [7:0] SEQ_TAG_BYTE = 8'h30;
	localparam logic [7:0] INT_TAG_BYTE = 8'h02;

	// long form length: this many or more significant length bytes fails
	localparam int LEN_BYTES_LIMIT = 8;
	localparam int INT_BYTES_DEF   = 32;

	localparam int LEN_W   = 56;   // length counter width
	localparam int LEFT_W  = 7;    // length bytes still to come
	localparam int WORD_W  = 64;
	localparam int VALUE_W = 256;  // R and S as seen on the result port

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] r_value;
		logic [VALUE_W-1:0] s_value;
		logic               parse_ok;
		logic               overflow;
	} result_t;

	// per cycle control from the top to the stages
	typedef struct packed {
		logic advance;  // input register hands its byte to the parser
		logic emit;     // that byte ends the frame: load the result register
	} step_ctl_t;

endpackage

>>> rtl/core/ldsp_in_stage.sv
// ----------------------------------------------------------------------------
// ldsp_in_stage
// Input register: one byte held until the parser takes it.
// ----------------------------------------------------------------------------
module ldsp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ldsp_pkg::in_item_t in_item,
	input  ldsp_pkg::step_ctl_t ctl,
	output logic               valid_s1,
	output ldsp_pkg::in_item_t item_s1
);

	assign in_ready = !valid_s1 || ctl.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> rtl/core/ldsp_parse.sv
// ----------------------------------------------------------------------------
// ldsp_parse
// Parser state and per-byte update; forms the frame result on the last byte.
// ----------------------------------------------------------------------------
module ldsp_parse #(
	parameter int INT_BYTES = ldsp_pkg::INT_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ldsp_pkg::step_ctl_t ctl,
	input  ldsp_pkg::in_item_t  item_s1,
	output ldsp_pkg::result_t   result
);

	localparam int VW    = 8 * INT_BYTES;
	localparam int EFF_W = $clog2(INT_BYTES + 2);
	localparam int LEN_W = ldsp_pkg::LEN_W;
	localparam int LFT_W = ldsp_pkg::LEFT_W;

	typedef enum logic [3:0] {
		PH_SEQ_TAG, PH_SEQ_LEN, PH_SEQ_SKIP,
		PH_R_TAG, PH_R_LEN, PH_R_LENB, PH_R_VAL,
		PH_S_TAG, PH_S_LEN, PH_S_LENB, PH_S_VAL,
		PH_DONE
	} phase_t;

	phase_t           phase_q, phase_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [LFT_W-1:0] left_q, left_n;
	logic [VW-1:0]    r_val_q, r_val_n, s_val_q, s_val_n;
	logic [EFF_W-1:0] r_eff_q, r_eff_n, s_eff_q, s_eff_n;
	logic             nz_q, nz_n;
	logic             fail_q, fail_n;

	logic [7:0]       b;
	logic             is_s;
	phase_t           p_len, p_lenb, p_val, p_end;
	logic [LEN_W-1:0] len_shifted;
	logic [VW+7:0]    r_cat, s_cat;
	logic             ok, ovf, zero;
	logic [ldsp_pkg::VALUE_W-1:0] r_full, s_full;

	assign b    = item_s1.data_byte;
	assign is_s = (phase_q == PH_S_TAG) || (phase_q == PH_S_LEN) ||
	              (phase_q == PH_S_LENB) || (phase_q == PH_S_VAL);

	assign p_len  = is_s ? PH_S_LEN  : PH_R_LEN;
	assign p_lenb = is_s ? PH_S_LENB : PH_R_LENB;
	assign p_val  = is_s ? PH_S_VAL  : PH_R_VAL;
	assign p_end  = is_s ? PH_DONE   : PH_S_TAG;

	assign len_shifted = {len_q[LEN_W-9:0], b};
	assign r_cat = {r_val_q, b};
	assign s_cat = {s_val_q, b};

	always_comb begin
		phase_n = phase_q;
		len_n   = len_q;
		left_n  = left_q;
		r_val_n = r_val_q;
		s_val_n = s_val_q;
		r_eff_n = r_eff_q;
		s_eff_n = s_eff_q;
		nz_n    = nz_q;
		fail_n  = fail_q;
		if (!fail_q) begin
			unique case (phase_q)
				PH_SEQ_TAG: begin
					if (b != ldsp_pkg::SEQ_TAG_BYTE) fail_n = 1'b1;
					else phase_n = PH_SEQ_LEN;
				end
				PH_SEQ_LEN: begin
					if (b[7] && (b[6:0] != '0)) begin
						left_n  = b[6:0];
						phase_n = PH_SEQ_SKIP;
					end else begin
						phase_n = PH_R_TAG;
					end
				end
				PH_SEQ_SKIP: begin
					left_n = left_q - 1'b1;
					if (left_n == '0) phase_n = PH_R_TAG;
				end
				PH_R_TAG, PH_S_TAG: begin
					if (b != ldsp_pkg::INT_TAG_BYTE) fail_n = 1'b1;
					else phase_n = p_len;
				end
				PH_R_LEN, PH_S_LEN: begin
					nz_n = 1'b0;
					if (!b[7]) begin
						len_n   = LEN_W'(b);
						phase_n = (b == '0) ? p_end : p_val;
					end else begin
						left_n  = b[6:0];
						len_n   = '0;
						phase_n = (b[6:0] == '0) ? p_end : p_lenb;
					end
				end
				PH_R_LENB, PH_S_LENB: begin
					if (!nz_q && (b != '0) &&
					    (left_q >= LFT_W'(ldsp_pkg::LEN_BYTES_LIMIT))) begin
						fail_n = 1'b1;
					end else begin
						nz_n   = nz_q || (b != '0);
						if (nz_n) len_n = len_shifted;
						left_n = left_q - 1'b1;
						if (left_n == '0) begin
							nz_n    = 1'b0;
							phase_n = (len_n == '0) ? p_end : p_val;
						end
					end
				end
				PH_R_VAL, PH_S_VAL: begin
					// leading zero value bytes are dropped
					if (nz_q || (b != '0)) begin
						nz_n = 1'b1;
						if (is_s) begin
							s_val_n = s_cat[VW-1:0];
							if (s_eff_q <= EFF_W'(INT_BYTES)) s_eff_n = s_eff_q + 1'b1;
						end else begin
							r_val_n = r_cat[VW-1:0];
							if (r_eff_q <= EFF_W'(INT_BYTES)) r_eff_n = r_eff_q + 1'b1;
						end
					end
					len_n = len_q - 1'b1;
					if (len_n == '0) phase_n = p_end;
				end
				PH_DONE: begin
					// trailing bytes are ignored
				end
				default: fail_n = 1'b1;
			endcase
		end
	end

	always_comb begin
		ok   = !fail_n && (phase_n == PH_DONE);
		ovf  = ok && ((r_eff_n > EFF_W'(INT_BYTES)) || (s_eff_n > EFF_W'(INT_BYTES)));
		zero = !ok || ovf;
		r_full = '0;
		s_full = '0;
		if (!zero) begin
			r_full[VW-1:0] = r_val_n;
			s_full[VW-1:0] = s_val_n;
		end
		result.r_value  = r_full;
		result.s_value  = s_full;
		result.parse_ok = ok;
		result.overflow = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEQ_TAG;
			len_q   <= '0;
			left_q  <= '0;
			r_val_q <= '0;
			s_val_q <= '0;
			r_eff_q <= '0;
			s_eff_q <= '0;
			nz_q    <= 1'b0;
			fail_q  <= 1'b0;
		end else if (ctl.advance && ctl.emit) begin
			// frame done: back to the start for the next one
			phase_q <= PH_SEQ_TAG;
			len_q   <= '0;
			left_q  <= '0;
			r_val_q <= '0;
			s_val_q <= '0;
			r_eff_q <= '0;
			s_eff_q <= '0;
			nz_q    <= 1'b0;
			fail_q  <= 1'b0;
		end else if (ctl.advance) begin
			phase_q <= phase_n;
			len_q   <= len_n;
			left_q  <= left_n;
			r_val_q <= r_val_n;
			s_val_q <= s_val_n;
			r_eff_q <= r_eff_n;
			s_eff_q <= s_eff_n;
			nz_q    <= nz_n;
			fail_q  <= fail_n;
		end
	end

endmodule

>>> rtl/core/ldsp_out_stage.sv
// ----------------------------------------------------------------------------
// ldsp_out_stage
// Result register: holds one frame result until the sink takes it.
// ----------------------------------------------------------------------------
module ldsp_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  ldsp_pkg::step_ctl_t ctl,
	input  ldsp_pkg::result_t   result,
	input  logic                out_ready,
	output logic                out_free,
	output logic                valid_s2,
	output ldsp_pkg::result_t   result_s2
);

	assign out_free = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.advance && ctl.emit) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance && ctl.emit) begin
			result_s2 <= result;
		end
	end

endmodule

>>> rtl/core/lax_der_ecdsa_signature_parser.sv
// ----------------------------------------------------------------------------
// lax_der_ecdsa_signature_parser
// Lax DER parser for ECDSA signatures, one byte per cycle unless a result waits, R and S out.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                   ends a request
//  s_axis    in   tdata: data_byte, tlast: is_last          tvalid & tready
//  m_axis    out  tdata: R and S words, tuser: ok, overflow tvalid & tready
//
//  Cycles: one byte per cycle while no result waits; a result is presented
//  once its last byte has passed the input register and the parser has
//  loaded the result register, which a waiting result holds up.
//  Reset: arst_n clears the valid flags and all parser state at once; no clearing pass is needed.
//  Stalls: a waiting result holds up only the next last byte and the input behind it;
//  other bytes of the following frame keep flowing into the parser meanwhile.
//
// Frame flow: tag 0x30, sequence length (skipped), then R and S as 0x02
// tag, short/long length, value. Leading zeros in long lengths and values
// are stripped; values are right aligned. Bytes after S are ignored.
// ----------------------------------------------------------------------------
module lax_der_ecdsa_signature_parser #(
	parameter int INT_BYTES = ldsp_pkg::INT_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,

	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tlast,   // is_last

	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [63:0] r_word3, [127:64] r_word2, [191:128] r_word1, [255:192] r_word0,
	// [319:256] s_word3, [383:320] s_word2, [447:384] s_word1,
	// [511:448] s_word0
	output logic [511:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser    // [0] parse_ok, [1] overflow
);

	localparam int WW = ldsp_pkg::WORD_W;

	ldsp_pkg::in_item_t  in_item;
	ldsp_pkg::in_item_t  item_s1;
	ldsp_pkg::step_ctl_t ctl;
	ldsp_pkg::result_t   result;
	ldsp_pkg::result_t   result_s2;
	logic                valid_s1;
	logic                out_free;

	assign in_item.data_byte = s_axis_tdata;
	assign in_item.is_last   = s_axis_tlast;

	// a non-last byte always moves on; the last byte waits for a free
	// result register
	assign ctl.advance = valid_s1 && (!item_s1.is_last || out_free);
	assign ctl.emit    = item_s1.is_last;

	ldsp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.ctl      (ctl),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ldsp_parse #(
		.INT_BYTES (INT_BYTES)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.item_s1 (item_s1),
		.result  (result)
	);

	ldsp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.result    (result),
		.out_ready (m_axis_tready),
		.out_free  (out_free),
		.valid_s2  (m_axis_tvalid),
		.result_s2 (result_s2)
	);

	// most significant word of each value in the lowest tdata bits
	assign m_axis_tdata[WW*1-1:WW*0] = result_s2.r_value[WW*4-1:WW*3];
	assign m_axis_tdata[WW*2-1:WW*1] = result_s2.r_value[WW*3-1:WW*2];
	assign m_axis_tdata[WW*3-1:WW*2] = result_s2.r_value[WW*2-1:WW*1];
	assign m_axis_tdata[WW*4-1:WW*3] = result_s2.r_value[WW*1-1:WW*0];
	assign m_axis_tdata[WW*5-1:WW*4] = result_s2.s_value[WW*4-1:WW*3];
	assign m_axis_tdata[WW*6-1:WW*5] = result_s2.s_value[WW*3-1:WW*2];
	assign m_axis_tdata[WW*7-1:WW*6] = result_s2.s_value[WW*2-1:WW*1];
	assign m_axis_tdata[WW*8-1:WW*7] = result_s2.s_value[WW*1-1:WW*0];
	assign m_axis_tuser[0] = result_s2.parse_ok;
	assign m_axis_tuser[1] = result_s2.overflow;

	// overflow is only reported on a well formed frame
	a_ovf_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tuser[1] || m_axis_tuser[0]))
		else $error("overflow without parse_ok");

	// failed or oversized frames carry zero values
	a_zero_values: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (!m_axis_tuser[0] || m_axis_tuser[1])) |->
		(m_axis_tdata == '0))
		else $error("nonzero values on failed or oversized frame");

	// a byte held in the input register is not lost while it waits
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ctl.advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register dropped a waiting byte");

	// a frame end only moves on when the result register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.advance && ctl.emit) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lax DER signature parser: directed frames from
// a table, then random, mostly well-formed frames under four idle/stall
// phases; every result is checked field by field against a hand-typed value or a local parser.
// ----------------------------------------------------------------------------
module tb;

	localparam int          CLK_HALF     = 5;
	localparam int          CYCLE_LIMIT  = 300000;
	localparam int          DRAIN_CYCLES = 10;
	localparam int          ROW_BYTES    = 80;
	localparam logic [7:0]  LONG_FORM    = 8'h80;

	// parser phases: sequence header, then two integer blocks of tag, length, length bytes and value steps
	localparam logic [3:0]  P_SEQ_TAG  = 4'd0;
	localparam logic [3:0]  P_SEQ_LEN  = 4'd1;
	localparam logic [3:0]  P_SEQ_SKIP = 4'd2;
	localparam logic [3:0]  P_R_BASE   = 4'd3;
	localparam logic [3:0]  P_S_BASE   = 4'd7;
	localparam logic [3:0]  P_DONE     = 4'd11;
	// offsets inside an integer block
	localparam logic [3:0]  OFF_TAG  = 4'd0;
	localparam logic [3:0]  OFF_LEN  = 4'd1;
	localparam logic [3:0]  OFF_LENB = 4'd2;
	localparam logic [3:0]  OFF_VAL  = 4'd3;
	localparam logic [3:0]  OFF_END  = 4'd4;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [511:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	lax_der_ecdsa_signature_parser uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #(CLK_HALF) clk = ~clk;

	// per frame: either a hand-typed signature or "take the parser's word"
	typedef struct {
		bit                fixed;
		ldsp_pkg::result_t sig;
	} pin_t;

	// directed stimulus row: bytes right aligned, first byte highest
	typedef struct {
		int unsigned              n;
		logic [8*ROW_BYTES-1:0]   bytes;
		bit                       fixed;
		ldsp_pkg::result_t        sig;
	} row_t;

	row_t              rows[$];
	logic [7:0]        frame_bytes[$];
	ldsp_pkg::result_t expected_sigs[$];
	pin_t              pinned_sigs[$];
	int                errors = 0;
	int                cycles = 0;
	int unsigned       idle_pct = 0;
	int unsigned       stall_pct = 0;

	// ------------------------------------------------------------------------
	// Signature parser state (mirror of the block)
	// ------------------------------------------------------------------------
	logic [3:0]   ph;
	logic [55:0]  len_cnt;
	logic [7:0]   len_left;
	logic [255:0] r_acc, s_acc;
	int unsigned  r_len, s_len;
	logic         nz_seen, broken;

	function automatic void parser_clear();
		ph       = P_SEQ_TAG;
		len_cnt  = '0;
		len_left = '0;
		r_acc    = '0;
		s_acc    = '0;
		r_len    = 0;
		s_len    = 0;
		nz_seen  = 1'b0;
		broken   = 1'b0;
	endfunction

	function automatic void start_value(logic [3:0] base, logic [55:0] cnt);
		nz_seen = 1'b0;
		len_cnt = cnt;
		ph      = (cnt == '0) ? base + OFF_END : base + OFF_VAL;
	endfunction

	function automatic void integer_byte(logic [3:0] base, logic [7:0] b);
		logic [3:0] off;
		off = ph - base;
		case (off)
			OFF_TAG: begin
				if (b != ldsp_pkg::INT_TAG_BYTE) broken = 1'b1;
				else ph = base + OFF_LEN;
			end
			OFF_LEN: begin
				if (!b[7]) begin
					start_value(base, {48'd0, b});
				end else begin
					len_left = {1'b0, b[6:0]};
					nz_seen  = 1'b0;
					len_cnt  = '0;
					if (len_left == '0) start_value(base, '0);
					else ph = base + OFF_LENB;
				end
			end
			OFF_LENB: begin
				// first significant length byte: too many left means reject
				if (!nz_seen && b != 8'h00) begin
					if (len_left >= ldsp_pkg::LEN_BYTES_LIMIT) begin
						broken = 1'b1;
						return;
					end
					nz_seen = 1'b1;
				end
				if (nz_seen) len_cnt = {len_cnt[47:0], b};
				len_left = len_left - 8'd1;
				if (len_left == '0) start_value(base, len_cnt);
			end
			default: begin
				// value byte: leading zeros dropped, rest shifted in from the right
				if (nz_seen || b != 8'h00) begin
					nz_seen = 1'b1;
					if (base == P_R_BASE) begin
						if (r_len <= ldsp_pkg::INT_BYTES_DEF) r_len++;
						r_acc = {r_acc[247:0], b};
					end else begin
						if (s_len <= ldsp_pkg::INT_BYTES_DEF) s_len++;
						s_acc = {s_acc[247:0], b};
					end
				end
				len_cnt = len_cnt - 56'd1;
				if (len_cnt == '0) ph = base + OFF_END;
			end
		endcase
	endfunction

	function automatic void parse_der_byte(input logic [7:0] b, input logic last,
			output logic emit, output ldsp_pkg::result_t sig);
		logic ok, ovf;
		if (!broken) begin
			if (ph == P_SEQ_TAG) begin
				if (b != ldsp_pkg::SEQ_TAG_BYTE) broken = 1'b1;
				else ph = P_SEQ_LEN;
			end else if (ph == P_SEQ_LEN) begin
				if (b[7] && b[6:0] != 7'd0) begin
					len_left = {1'b0, b[6:0]};
					ph       = P_SEQ_SKIP;
				end else begin
					ph = P_R_BASE;
				end
			end else if (ph == P_SEQ_SKIP) begin
				len_left = len_left - 8'd1;
				if (len_left == '0) ph = P_R_BASE;
			end else if (ph >= P_R_BASE && ph < P_S_BASE) begin
				integer_byte(P_R_BASE, b);
			end else if (ph >= P_S_BASE && ph < P_DONE) begin
				integer_byte(P_S_BASE, b);
			end
		end
		emit = last;
		sig  = '0;
		if (last) begin
			ok  = !broken && ph == P_DONE;
			ovf = ok && (r_len > ldsp_pkg::INT_BYTES_DEF || s_len > ldsp_pkg::INT_BYTES_DEF);
			sig.parse_ok = ok;
			sig.overflow = ovf;
			if (ok && !ovf) begin
				sig.r_value = r_acc;
				sig.s_value = s_acc;
			end
			parser_clear();
		end
	endfunction

	// ------------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------------
	function automatic ldsp_pkg::result_t sig_of(logic ok, logic ovf, logic [255:0] r,
			logic [255:0] s);
		ldsp_pkg::result_t v;
		v.r_value  = r;
		v.s_value  = s;
		v.parse_ok = ok;
		v.overflow = ovf;
		return v;
	endfunction

	function automatic void add_row(int unsigned n, logic [8*ROW_BYTES-1:0] bytes,
			bit fixed, ldsp_pkg::result_t sig);
		row_t r;
		r.n     = n;
		r.bytes = bytes;
		r.fixed = fixed;
		r.sig   = sig;
		rows.push_back(r);
	endfunction

	function automatic void load_rows();
		ldsp_pkg::result_t none, bad;
		none = '0;
		bad  = sig_of(1'b0, 1'b0, '0, '0);
		// minimal good frame, first after reset
		add_row(8, {8'h30, 8'h06, 8'h02, 8'h01, 8'h05, 8'h02, 8'h01, 8'h07}, 1,
			sig_of(1'b1, 1'b0, 256'd5, 256'd7));
		// wrong sequence tag
		add_row(8, {8'h31, 8'h06, 8'h02, 8'h01, 8'h05, 8'h02, 8'h01, 8'h07}, 1, bad);
		// frame ends after the tag
		add_row(1, {8'h30}, 1, bad);
		// wrong integer tag
		add_row(8, {8'h30, 8'h06, 8'h03, 8'h01, 8'h05, 8'h02, 8'h01, 8'h07}, 1, bad);
		// long form sequence length, trailing bytes
		add_row(11, {8'h30, 8'h81, 8'h06, 8'h02, 8'h01, 8'h05, 8'h02, 8'h01, 8'h07,
			8'hAA, 8'hBB}, 0, none);
		// zero length integers, short form and bare long form
		add_row(6, {8'h30, 8'h00, 8'h02, 8'h00, 8'h02, 8'h80}, 1,
			sig_of(1'b1, 1'b0, '0, '0));
		// long form lengths made only of zero bytes
		add_row(11, {8'h30, 8'h00, 8'h02, 8'h82, 8'h00, 8'h00, 8'h02, 8'h83, 8'h00,
			8'h00, 8'h00}, 0, none);
		// eight significant length bytes: rejected
		add_row(12, {8'h30, 8'h00, 8'h02, 8'h88, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h01}, 1, bad);
		// eight length bytes, seven of them leading zeros: accepted
		add_row(17, {8'h30, 8'h00, 8'h02, 8'h88, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h02, 8'hAB, 8'hCD, 8'h02, 8'h01, 8'h7F}, 0, none);
		// leading zero value bytes, all-zero S value
		add_row(13, {8'h30, 8'h00, 8'h02, 8'h04, 8'h00, 8'h00, 8'h12, 8'h34, 8'h02,
			8'h03, 8'h00, 8'h00, 8'h00}, 0, none);
		// widest values, all ones
		add_row(70, {8'h30, 8'h44, 8'h02, 8'h20, {32{8'hFF}}, 8'h02, 8'h20, {32{8'hFF}}},
			1, sig_of(1'b1, 1'b0, '1, '1));
		// R one byte too long: overflow, values zeroed
		add_row(40, {8'h30, 8'h00, 8'h02, 8'h21, {33{8'h5A}}, 8'h02, 8'h01, 8'h01}, 1,
			sig_of(1'b1, 1'b1, '0, '0));
		// S too long even after its leading zero
		add_row(41, {8'h30, 8'h00, 8'h02, 8'h01, 8'h01, 8'h02, 8'h22, 8'h00,
			{33{8'hC3}}}, 0, none);
		// 33 bytes with one leading zero still fits
		add_row(40, {8'h30, 8'h00, 8'h02, 8'h21, 8'h00, {32{8'hFF}}, 8'h02, 8'h01,
			8'h80}, 0, none);
		// S value cut short
		add_row(9, {8'h30, 8'h00, 8'h02, 8'h01, 8'h01, 8'h02, 8'h05, 8'h11, 8'h22}, 1,
			bad);
		// two skipped sequence length bytes
		add_row(10, {8'h30, 8'h82, 8'h12, 8'h34, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01,
			8'h02}, 0, none);
		// seven significant length bytes: huge length, runs out of frame
		add_row(12, {8'h30, 8'h00, 8'h02, 8'h87, {7{8'hFF}}, 8'h01}, 1, bad);
		// single-byte noise frames
		add_row(1, {8'h00}, 1, bad);
		add_row(1, {8'hFF}, 1, bad);
	endfunction

	// ------------------------------------------------------------------------
	// Random frame builder
	// ------------------------------------------------------------------------
	function automatic void put_len(int unsigned n);
		int unsigned pick, pad, sig, k;
		pick = $urandom_range(99);
		if (pick < 3) begin
			// too many length bytes with a significant first one
			k = $urandom_range(ldsp_pkg::LEN_BYTES_LIMIT, 127);
			frame_bytes.push_back(LONG_FORM | 8'(k));
			frame_bytes.push_back(8'($urandom_range(1, 255)));
		end else if (pick < 5) begin
			// legal but huge length: value never completes
			k = $urandom_range(4, ldsp_pkg::LEN_BYTES_LIMIT - 1);
			frame_bytes.push_back(LONG_FORM | 8'(k));
			frame_bytes.push_back(8'($urandom_range(1, 255)));
			repeat (k - 1) frame_bytes.push_back(8'($urandom));
		end else if (n < 128 && pick < 60) begin
			frame_bytes.push_back(8'(n));
		end else begin
			pad = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
			sig = (n == 0) ? 0 : ((n < 256) ? 1 : 2);
			frame_bytes.push_back(LONG_FORM | 8'(pad + sig));
			repeat (pad) frame_bytes.push_back(8'h00);
			if (sig == 2) frame_bytes.push_back(8'(n >> 8));
			if (sig >= 1) frame_bytes.push_back(8'(n));
		end
	endfunction

	function automatic void put_int();
		int unsigned sig_len, zpad, pick;
		logic [7:0]  b;
		frame_bytes.push_back(($urandom_range(49) == 0) ? 8'($urandom) :
			ldsp_pkg::INT_TAG_BYTE);
		pick = $urandom_range(99);
		if (pick < 55) sig_len = $urandom_range(0, 8);
		else if (pick < 90) sig_len = $urandom_range(9, ldsp_pkg::INT_BYTES_DEF);
		else sig_len = $urandom_range(ldsp_pkg::INT_BYTES_DEF + 1,
			ldsp_pkg::INT_BYTES_DEF + 3);
		zpad = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
		put_len(sig_len + zpad);
		repeat (zpad) frame_bytes.push_back(8'h00);
		for (int i = 0; i < sig_len; i++) begin
			b = 8'($urandom);
			if (i == 0 && b == 8'h00) b = 8'($urandom_range(1, 255));
			frame_bytes.push_back(b);
		end
	endfunction

	function automatic void build_frame();
		int unsigned pick, k;
		frame_bytes.delete();
		pick = $urandom_range(99);
		if (pick < 5) begin
			// pure noise
			k = $urandom_range(1, 8);
			repeat (k) frame_bytes.push_back(8'($urandom));
		end else begin
			frame_bytes.push_back(($urandom_range(49) == 0) ? 8'($urandom) :
				ldsp_pkg::SEQ_TAG_BYTE);
			pick = $urandom_range(19);
			if (pick < 12) begin
				frame_bytes.push_back(8'($urandom_range(0, 127)));
			end else begin
				k = (pick == 19) ? $urandom_range(4, 127) : $urandom_range(0, 3);
				frame_bytes.push_back(LONG_FORM | 8'(k));
				repeat (k) frame_bytes.push_back(8'($urandom));
			end
			put_int();
			put_int();
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
			// occasionally cut the frame short
			if ($urandom_range(19) == 0) begin
				k = $urandom_range(1, frame_bytes.size() - 1);
				while (frame_bytes.size() > k) void'(frame_bytes.pop_back());
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Sender: one request per byte, random gaps before it
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic last);
		logic rdy;
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		rdy = 1'b0;
		// tready settles by the falling edge; it holds through the next rising one
		while (!rdy) begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end
	endtask

	task automatic send_frame(input bit fixed, input ldsp_pkg::result_t sig);
		pin_t p;
		p.fixed = fixed;
		p.sig   = sig;
		pinned_sigs.push_back(p);
		foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// receiver: random stalls at the current rate
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("lax_der_ecdsa_signature_parser test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: both sides sampled mid-cycle, values hold across the next edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : monitor
		logic              emit;
		ldsp_pkg::result_t pred, want;
		pin_t              pin;
		logic [63:0]       got_w;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				parse_der_byte(s_axis_tdata, s_axis_tlast, emit, pred);
				if (emit) begin
					pin = pinned_sigs.pop_front();
					expected_sigs.push_back(pin.fixed ? pin.sig : pred);
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_sigs.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, ok %b ovf %b", $time,
						m_axis_tuser[0], m_axis_tuser[1]);
				end else begin
					want = expected_sigs.pop_front();
					// tdata words run r_word3..r_word0, then s_word3..s_word0
					for (int k = 3; k >= 0; k--) begin
						got_w = m_axis_tdata[64*(3-k) +: 64];
						if (got_w !== want.r_value[64*k +: 64]) begin
							errors++;
							$display("%0t: r_word%0d expected %h, got %h", $time, k,
								want.r_value[64*k +: 64], got_w);
						end
						got_w = m_axis_tdata[256 + 64*(3-k) +: 64];
						if (got_w !== want.s_value[64*k +: 64]) begin
							errors++;
							$display("%0t: s_word%0d expected %h, got %h", $time, k,
								want.s_value[64*k +: 64], got_w);
						end
					end
					if (m_axis_tuser[0] !== want.parse_ok) begin
						errors++;
						$display("%0t: parse_ok expected %b, got %b", $time,
							want.parse_ok, m_axis_tuser[0]);
					end
					if (m_axis_tuser[1] !== want.overflow) begin
						errors++;
						$display("%0t: overflow expected %b, got %b", $time,
							want.overflow, m_axis_tuser[1]);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stim
		int unsigned rand_bytes, rand_frames;
		rand_bytes  = 0;
		rand_frames = 0;
		parser_clear();
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// directed frames, no idling
		load_rows();
		foreach (rows[i]) begin
			frame_bytes.delete();
			for (int k = 0; k < rows[i].n; k++)
				frame_bytes.push_back(rows[i].bytes[8*(rows[i].n-1-k) +: 8]);
			send_frame(rows[i].fixed, rows[i].sig);
		end

		// random frames: free run, sender gaps, receiver stalls, both
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 74; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 74; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			while (rand_bytes < 300 * (p + 1) || (p == 3 && rand_frames < 60)) begin
				build_frame();
				rand_bytes += frame_bytes.size();
				rand_frames++;
				send_frame(1'b0, '0);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (expected_sigs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_sigs.size() == 0) begin
			$display("lax_der_ecdsa_signature_parser test passed");
		end else begin
			$display("lax_der_ecdsa_signature_parser test failed");
		end
		$finish;
	end

endmodule
